@@ rtl/delimited_token_splitter_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the delimited token splitter.
// Each macro expects clk and rst_n to be visible in the module that uses it.
// ----------------------------------------------------------------------------
`ifndef DELIMITED_TOKEN_SPLITTER_TOP_MACROS_SVH
`define DELIMITED_TOKEN_SPLITTER_TOP_MACROS_SVH
`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define DTS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition must never be true outside reset.
`define DTS_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define DTS_ASSERT(name, prop, msg)
`define DTS_ASSERT_NEVER(name, cond, msg)
`endif
`endif

@@ rtl/dts_pkg.sv @@
// ----------------------------------------------------------------------------
// dts_pkg
// Shared types and constants of the delimited token splitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dts_pkg;

  localparam int POS_W      = 16;
  localparam int CHAR_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int MAP_WORDS  = 4;

  // Longest string in bytes; later bytes are dropped and flagged.
  localparam logic [POS_W-1:0] MAX_LENGTH = 16'hFFFF;

  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'd9;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_LO     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_MID_LO = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_MID_HI = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_HI     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ALLOW_EMPTY  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_TRAIL   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TRIM_TOKENS  = 3'd6;

  // Queue between the classifier and the emitter; depth is a power of two.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic [POS_W-1:0] start;
    logic [POS_W-1:0] len;
  } tok_t;

  // Everything one input byte produces: one or two tokens.
  typedef struct packed {
    logic two;
    logic str_last;
    logic ovf;
    tok_t t0;
    tok_t t1;
  } entry_t;

endpackage

`default_nettype wire

@@ rtl/dts_in_if.sv @@
// ----------------------------------------------------------------------------
// dts_in_if
// Byte input channel: one string byte per item with an end marker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dts_in_if;
  logic                         valid;
  logic                         ready;
  logic [dts_pkg::CHAR_W-1:0]   char_code;
  logic                         end_of_string;

  modport source (output valid, output char_code, output end_of_string, input ready);
  modport sink   (input valid, input char_code, input end_of_string, output ready);
endinterface

`default_nettype wire

@@ rtl/dts_out_if.sv @@
// ----------------------------------------------------------------------------
// dts_out_if
// Token result channel: start offset, length and flags per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dts_out_if;
  logic                        valid;
  logic                        ready;
  logic [dts_pkg::POS_W-1:0]   token_start;
  logic [dts_pkg::POS_W-1:0]   token_length;
  logic                        run_last;
  logic                        string_last;
  logic                        length_overflow;

  modport source (output valid, output token_start, output token_length,
                  output run_last, output string_last, output length_overflow,
                  input ready);
  modport sink   (input valid, input token_start, input token_length,
                  input run_last, input string_last, input length_overflow,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/dts_cfg_if.sv @@
// ----------------------------------------------------------------------------
// dts_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dts_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [dts_pkg::CFG_IDX_W-1:0]    index;
  logic [dts_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/dts_front.sv @@
// ----------------------------------------------------------------------------
// dts_front
// Holds configuration and string state, classifies each byte and builds
// the token entry it produces.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dts_front (
  input  wire logic      clk,
  input  wire logic      rst_n,
  dts_in_if.sink         in_ch,
  dts_cfg_if.sink        cfg_ch,
  input  wire logic      full,
  output logic           wr_en,
  output dts_pkg::entry_t wr_entry
);

  logic [dts_pkg::MAP_WORDS-1:0][dts_pkg::CFG_DATA_W-1:0] delim_map_r;
  logic allow_r, keep_r, trim_r;

  logic [dts_pkg::POS_W-1:0] pos_r, seg_r, first_r, last_r;
  logic seen_r, ovf_r;
  logic [dts_pkg::POS_W-1:0] pos_nxt, seg_nxt, first_nxt, last_nxt;
  logic seen_nxt, ovf_nxt;

  logic ovf_now, delim, blank, delim_step, content, accept, trailing;
  logic emit_a, emit_b;
  logic [dts_pkg::POS_W-1:0] pos1, seg1, first1, last1;
  logic seen1;
  dts_pkg::tok_t tok_a, tok_b_close, tok_b;

  // Token bounds of the open segment that ends just before end_pos.
  function automatic dts_pkg::tok_t close_seg(
    input logic trim, input logic seen,
    input logic [dts_pkg::POS_W-1:0] first, input logic [dts_pkg::POS_W-1:0] last,
    input logic [dts_pkg::POS_W-1:0] seg, input logic [dts_pkg::POS_W-1:0] end_pos
  );
    dts_pkg::tok_t t;
    if (trim) begin
      if (seen) begin
        t.start = first;
        t.len   = last - first + 16'd1;
      end else begin
        t.start = end_pos;
        t.len   = '0;
      end
    end else begin
      t.start = seg;
      t.len   = end_pos - seg;
    end
    return t;
  endfunction

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_map_r <= '0;
      allow_r     <= 1'b0;
      keep_r      <= 1'b0;
      trim_r      <= 1'b0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        dts_pkg::REG_DELIM_LO:     delim_map_r[0] <= cfg_ch.data;
        dts_pkg::REG_DELIM_MID_LO: delim_map_r[1] <= cfg_ch.data;
        dts_pkg::REG_DELIM_MID_HI: delim_map_r[2] <= cfg_ch.data;
        dts_pkg::REG_DELIM_HI:     delim_map_r[3] <= cfg_ch.data;
        dts_pkg::REG_ALLOW_EMPTY:  allow_r        <= cfg_ch.data[0];
        dts_pkg::REG_KEEP_TRAIL:   keep_r         <= cfg_ch.data[0];
        dts_pkg::REG_TRIM_TOKENS:  trim_r         <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = !full;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    ovf_now    = (pos_r >= dts_pkg::MAX_LENGTH);
    delim      = delim_map_r[in_ch.char_code[7:6]][in_ch.char_code[5:0]];
    blank      = (in_ch.char_code == dts_pkg::CHAR_SPACE) ||
                 (in_ch.char_code == dts_pkg::CHAR_TAB);
    delim_step = !ovf_now && delim;
    content    = !ovf_now && !delim && !blank;

    pos1   = ovf_now ? pos_r : pos_r + 16'd1;
    seg1   = delim_step ? pos1 : seg_r;
    seen1  = delim_step ? 1'b0 : (seen_r || content);
    first1 = (content && !seen_r) ? pos_r : first_r;
    last1  = content ? pos_r : last_r;

    // Token closed by a delimiter byte.
    tok_a  = close_seg(trim_r, seen_r, first_r, last_r, seg_r, pos_r);
    emit_a = delim_step && ((tok_a.len != '0) || allow_r);

    // Token closed by the end of the string.
    trailing    = (pos1 != '0) && (seg1 == pos1);
    tok_b_close = close_seg(trim_r, seen1, first1, last1, seg1, pos1);
    if (trailing) begin
      tok_b.start = pos1;
      tok_b.len   = '0;
      emit_b      = in_ch.end_of_string && allow_r && keep_r;
    end else begin
      tok_b  = tok_b_close;
      emit_b = in_ch.end_of_string && ((tok_b_close.len != '0) || allow_r);
    end

    wr_entry.two      = emit_a && emit_b;
    wr_entry.str_last = in_ch.end_of_string;
    wr_entry.ovf      = ovf_r || ovf_now;
    wr_entry.t0       = emit_a ? tok_a : tok_b;
    wr_entry.t1       = tok_b;
    wr_en             = accept && (emit_a || emit_b);

    pos_nxt   = pos_r;
    seg_nxt   = seg_r;
    first_nxt = first_r;
    last_nxt  = last_r;
    seen_nxt  = seen_r;
    ovf_nxt   = ovf_r;
    if (accept) begin
      if (in_ch.end_of_string) begin
        pos_nxt   = '0;
        seg_nxt   = '0;
        first_nxt = '0;
        last_nxt  = '0;
        seen_nxt  = 1'b0;
        ovf_nxt   = 1'b0;
      end else begin
        pos_nxt   = pos1;
        seg_nxt   = seg1;
        first_nxt = first1;
        last_nxt  = last1;
        seen_nxt  = seen1;
        ovf_nxt   = ovf_r || ovf_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      seg_r   <= '0;
      first_r <= '0;
      last_r  <= '0;
      seen_r  <= 1'b0;
      ovf_r   <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      seg_r   <= seg_nxt;
      first_r <= first_nxt;
      last_r  <= last_nxt;
      seen_r  <= seen_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/dts_fifo.sv @@
// ----------------------------------------------------------------------------
// dts_fifo
// Short queue of token entries between the classifier and the emitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "delimited_token_splitter_top_macros.svh"

module dts_fifo (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire dts_pkg::entry_t  wr_entry,
  output logic                  full,
  output logic                  rd_valid,
  output dts_pkg::entry_t       rd_entry,
  input  wire logic             rd_en
);

  dts_pkg::entry_t mem_r [dts_pkg::FIFO_DEPTH];
  logic [dts_pkg::FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [dts_pkg::FIFO_AW:0]   count_r, count_nxt;
  logic do_wr, do_rd;

  assign full     = (count_r == (dts_pkg::FIFO_AW+1)'(dts_pkg::FIFO_DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_entry = mem_r[rd_ptr_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `DTS_ASSERT(a_count_bound, count_r <= (dts_pkg::FIFO_AW+1)'(dts_pkg::FIFO_DEPTH), "overrun")
  `DTS_ASSERT_NEVER(a_no_push_full, wr_en && full, "entry pushed into a full queue")
  `DTS_ASSERT(a_ptr_gap, (!rd_valid || full) == (wr_ptr_r == rd_ptr_r), "pointers disagree")

endmodule

`default_nettype wire

@@ rtl/dts_back.sv @@
// ----------------------------------------------------------------------------
// dts_back
// Takes queued entries apart into single tokens and drives the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "delimited_token_splitter_top_macros.svh"

module dts_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             rd_valid,
  input  wire dts_pkg::entry_t  rd_entry,
  output logic                  rd_en,
  dts_out_if.source             out_ch
);

  logic out_valid_r, out_valid_nxt;
  logic phase_r, phase_nxt;
  logic load, first_of_two;
  dts_pkg::tok_t tok_r, tok_nxt;
  logic run_last_r, run_last_nxt, str_last_r, str_last_nxt, ovf_r, ovf_nxt;

  // A new result may enter when the register is empty or being drained.
  assign load         = rd_valid && (!out_valid_r || out_ch.ready);
  assign first_of_two = rd_entry.two && !phase_r;
  assign rd_en        = load && !first_of_two;

  always_comb begin
    out_valid_nxt = out_valid_r;
    phase_nxt     = phase_r;
    tok_nxt       = tok_r;
    run_last_nxt  = run_last_r;
    str_last_nxt  = str_last_r;
    ovf_nxt       = ovf_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
      ovf_nxt       = rd_entry.ovf;
      if (first_of_two) begin
        tok_nxt      = rd_entry.t0;
        run_last_nxt = 1'b0;
        str_last_nxt = 1'b0;
        phase_nxt    = 1'b1;
      end else begin
        tok_nxt      = phase_r ? rd_entry.t1 : rd_entry.t0;
        run_last_nxt = 1'b1;
        str_last_nxt = rd_entry.str_last;
        phase_nxt    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tok_r      <= tok_nxt;
    run_last_r <= run_last_nxt;
    str_last_r <= str_last_nxt;
    ovf_r      <= ovf_nxt;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.token_start     = tok_r.start;
  assign out_ch.token_length    = tok_r.len;
  assign out_ch.run_last        = run_last_r;
  assign out_ch.string_last     = str_last_r;
  assign out_ch.length_overflow = ovf_r;

  `DTS_ASSERT(a_phase_has_entry, phase_r |-> rd_valid && rd_entry.two, "phase without pair")
  `DTS_ASSERT(a_phase_clears, phase_r && load |=> !phase_r, "phase stayed set")
  `DTS_ASSERT_NEVER(a_first_not_last, out_valid_r && !run_last_r && str_last_r, "early end")

endmodule

`default_nettype wire

@@ rtl/delimited_token_splitter_top.sv @@
// ----------------------------------------------------------------------------
// delimited_token_splitter_top
// Splits a byte stream into tokens at delimiter bytes and reports each token.
// ----------------------------------------------------------------------------
// Usage: bytes arrive on in_ch, one item per byte, end_of_string set on the
// last byte of each string. Each token leaves on out_ch as one item holding
// its start offset and length; run_last marks the last token a byte caused
// and string_last the final token of a string. A byte causes zero, one or
// two tokens. The delimiter map and the mode bits are written on cfg_ch,
// which is always ready, and must only be written while the block is idle.
// Timing: a token passes the queue and the output register before it shows
// on out_ch. Bytes enter at one per cycle unless the queue is full, tokens
// leave at one per cycle while out_ch.ready is high, and a byte that closes
// two tokens leaves as two items. The front classifier and the back emitter
// are parted by a four-entry queue, so the input keeps flowing while a
// result waits in the output register. When the receiver stalls, the queue
// fills and in_ch.ready drops only once all four entries hold pending
// tokens. Reset (rst_n low at a clock edge) clears the configuration, the
// string state, the queue and the output register; no item stays in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module delimited_token_splitter_top (
  input  wire logic  clk,
  input  wire logic  rst_n,
  dts_in_if.sink     in_ch,
  dts_cfg_if.sink    cfg_ch,
  dts_out_if.source  out_ch
);

  // Entry handed from the classifier into the queue.
  logic            wr_en;
  dts_pkg::entry_t wr_entry;
  logic            full;

  // Head of the queue as seen by the emitter.
  logic            rd_valid;
  logic            rd_en;
  dts_pkg::entry_t rd_entry;

  // Classifier: delimiter lookup, trimming and the open-segment bookkeeping.
  dts_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_ch   (cfg_ch),
    .full     (full),
    .wr_en    (wr_en),
    .wr_entry (wr_entry)
  );

  // Decoupling queue; a byte that yields no token pushes nothing.
  dts_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_entry (wr_entry),
    .full     (full),
    .rd_valid (rd_valid),
    .rd_entry (rd_entry),
    .rd_en    (rd_en)
  );

  // Emitter: splits two-token entries and owns the output register.
  dts_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_valid (rd_valid),
    .rd_entry (rd_entry),
    .rd_en    (rd_en),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

@@ tb/delimited_token_splitter_top_test.sv @@
// ----------------------------------------------------------------------------
// delimited_token_splitter_top_test
// Self-checking bench for the delimited token splitter. Byte strings go in
// on the input channel while a token predictor inside the bench tracks the
// string state. Every token that leaves the block is compared, field by
// field, with the oldest predicted token.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module delimited_token_splitter_top_test;

  localparam logic [dts_pkg::CHAR_W-1:0] CHAR_COMMA = 8'h2C;
  localparam logic [dts_pkg::CHAR_W-1:0] CHAR_PIPE  = 8'h7C;

  // Cycles to let pass once the last predicted token has arrived. A byte
  // that closes no token pushes nothing into the queue.
  localparam int IDLE_HOLDOFF   = 12;
  // Cycles without any accepted item before the run is declared hung. The
  // worst legal gap is a sender pause plus two tokens that each wait out a
  // receiver stall, so this is generous.
  localparam int WATCHDOG_LIMIT = 2000;

  // One predicted token, in the order of the result channel fields.
  typedef struct packed {
    logic [dts_pkg::POS_W-1:0] start;
    logic [dts_pkg::POS_W-1:0] len;
    logic                      run_last;
    logic                      string_last;
    logic                      ovf;
  } token_rec_t;

  logic clk;
  logic rst_n;

  dts_in_if  in_ch ();
  dts_cfg_if cfg_ch ();
  dts_out_if out_ch ();

  delimited_token_splitter_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch)
  );

  // Tokens predicted but not yet seen on the result channel, oldest first.
  token_rec_t expected_tokens[$];
  int         error_count;

  // Configuration as the predictor sees it; updated when a write is accepted.
  logic [255:0] delim_map;
  logic         allow_empty_cfg;
  logic         keep_trailing_cfg;
  logic         trim_cfg;
  // Byte codes that are delimiters under the current map; the random strings
  // draw from this list so that tokens actually get split.
  logic [dts_pkg::CHAR_W-1:0] delim_codes[$];

  // String state of the predictor. Offsets are kept wider than 16 bits so
  // that the saturation point can be compared without wrapping.
  int unsigned str_pos;
  int unsigned seg_begin;
  int unsigned first_nb_pos;
  int unsigned last_nb_pos;
  logic        seen_nb;
  logic        str_overflowed;

  // Random idling is switched per phase and, for the sender, per string; the last two phases run without it.
  logic sender_gaps_on;
  logic receiver_stalls_on;

  // The clock toggles every half period of 5 ns.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Every input is known from time zero. Reset is held low from time zero and
  // released at a falling edge, once, at the start of the run.
  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.char_code    = '0;
    in_ch.end_of_string = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = dts_pkg::REG_DELIM_LO;
    cfg_ch.data        = '0;
    sender_gaps_on     = 1'b0;
    receiver_stalls_on = 1'b0;
    error_count        = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // Receiver: ready changes only at falling edges. When stalls are enabled,
  // a stall starts now and then; otherwise ready stays up.
  initial begin
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (receiver_stalls_on && stall_left == 0 && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 16);
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Prints one line for a failed check and counts it.
  task automatic flag_error(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  // Closes the open segment at offset seg_end. The token is returned in tok;
  // the function result says whether the token is given at all, since empty
  // tokens only count in allow-empty mode.
  function automatic logic close_segment(input int unsigned seg_end,
                                         output token_rec_t tok);
    int unsigned tok_start;
    int unsigned tok_len;
    if (trim_cfg) begin
      if (seen_nb) begin
        tok_start = first_nb_pos;
        tok_len   = last_nb_pos - first_nb_pos + 1;
      end else begin
        // A segment of blanks only trims down to an empty token that sits
        // where the segment ends.
        tok_start = seg_end;
        tok_len   = 0;
      end
    end else begin
      tok_start = seg_begin;
      tok_len   = seg_end - seg_begin;
    end
    seen_nb         = 1'b0;
    tok.start       = tok_start[dts_pkg::POS_W-1:0];
    tok.len         = tok_len[dts_pkg::POS_W-1:0];
    tok.run_last    = 1'b0;
    tok.string_last = 1'b0;
    tok.ovf         = str_overflowed;
    return (tok_len != 0) || allow_empty_cfg;
  endfunction

  // Advances the predictor by one accepted byte and queues the tokens that
  // the byte closes, zero, one or two of them.
  function automatic void split_byte(input logic [dts_pkg::CHAR_W-1:0] code,
                                     input logic eos);
    token_rec_t toks[2];
    token_rec_t tok;
    int         n;
    n = 0;
    if (str_pos >= dts_pkg::MAX_LENGTH) begin
      // Past the position range the byte is dropped, whatever it is.
      str_overflowed = 1'b1;
    end else if (delim_map[code]) begin
      if (close_segment(str_pos, tok)) begin
        toks[n] = tok;
        n++;
      end
      str_pos++;
      seg_begin = str_pos;
    end else begin
      if (code != dts_pkg::CHAR_SPACE && code != dts_pkg::CHAR_TAB) begin
        if (!seen_nb) begin
          first_nb_pos = str_pos;
          seen_nb      = 1'b1;
        end
        last_nb_pos = str_pos;
      end
      str_pos++;
    end

    if (eos) begin
      if (str_pos > 0 && seg_begin == str_pos) begin
        // The last accepted byte was a delimiter. The empty token behind it
        // is given only when both empty-token modes are on.
        if (allow_empty_cfg && keep_trailing_cfg) begin
          toks[n] = '{start: str_pos[dts_pkg::POS_W-1:0], len: '0, run_last: 1'b0,
                      string_last: 1'b0, ovf: str_overflowed};
          n++;
        end
      end else if (close_segment(str_pos, tok)) begin
        toks[n] = tok;
        n++;
      end
      if (n > 0) toks[n-1].string_last = 1'b1;
    end
    if (n > 0) toks[n-1].run_last = 1'b1;

    for (int i = 0; i < n; i++) expected_tokens.push_back(toks[i]);

    if (eos) begin
      str_pos        = 0;
      seg_begin      = 0;
      first_nb_pos   = 0;
      last_nb_pos    = 0;
      seen_nb        = 1'b0;
      str_overflowed = 1'b0;
    end
  endfunction

  // Result checker: each accepted token is compared with the oldest one
  // predicted. Outputs are sampled at the rising edge.
  always @(posedge clk) begin
    token_rec_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_tokens.size() == 0) begin
        flag_error($sformatf("token with nothing expected: start %0d length %0d",
                             out_ch.token_start, out_ch.token_length));
      end else begin
        want = expected_tokens.pop_front();
        if (out_ch.token_start !== want.start)
          flag_error($sformatf("token_start %0d, expected %0d",
                               out_ch.token_start, want.start));
        if (out_ch.token_length !== want.len)
          flag_error($sformatf("token_length %0d, expected %0d",
                               out_ch.token_length, want.len));
        if (out_ch.run_last !== want.run_last)
          flag_error($sformatf("run_last %b, expected %b",
                               out_ch.run_last, want.run_last));
        if (out_ch.string_last !== want.string_last)
          flag_error($sformatf("string_last %b, expected %b",
                               out_ch.string_last, want.string_last));
        if (out_ch.length_overflow !== want.ovf)
          flag_error($sformatf("length_overflow %b, expected %b",
                               out_ch.length_overflow, want.ovf));
      end
    end
  end

  // Watchdog: ends the run when no item moves on any channel for too long.
  always @(posedge clk) begin
    int quiet_cycles;
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("ERROR: no item accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Sends one byte. Called and returning just after a falling edge; valid is
  // left high so back-to-back bytes go out without a bubble. With gaps on,
  // the sender sometimes drops valid before the byte.
  task automatic send_byte(input logic [dts_pkg::CHAR_W-1:0] code, input logic eos);
    int gap;
    if (sender_gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.char_code     <= code;
    in_ch.end_of_string <= eos;
    do @(posedge clk); while (!in_ch.ready);
    split_byte(code, eos);
    @(negedge clk);
  endtask

  // Sends a text string with the end marker on its last character.
  task automatic send_string(input string text);
    for (int i = 0; i < text.len(); i++) send_byte(text[i], i == text.len() - 1);
  endtask

  // Stops sending and waits until every predicted token has arrived, then
  // lets the block settle.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_tokens.size() != 0) @(negedge clk);
    repeat (IDLE_HOLDOFF) @(negedge clk);
  endtask

  // One register write; the caller lowers valid after its last write.
  task automatic write_reg(input logic [dts_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dts_pkg::CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      dts_pkg::REG_DELIM_LO:     delim_map[0   +: 64] = value;
      dts_pkg::REG_DELIM_MID_LO: delim_map[64  +: 64] = value;
      dts_pkg::REG_DELIM_MID_HI: delim_map[128 +: 64] = value;
      dts_pkg::REG_DELIM_HI:     delim_map[192 +: 64] = value;
      dts_pkg::REG_ALLOW_EMPTY:  allow_empty_cfg      = value[0];
      dts_pkg::REG_KEEP_TRAIL:   keep_trailing_cfg    = value[0];
      dts_pkg::REG_TRIM_TOKENS:  trim_cfg             = value[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Waits for the block to go idle and then writes every register.
  task automatic configure(input logic [255:0] map, input logic allow_empty,
                           input logic keep_trailing, input logic trim);
    wait_idle();
    write_reg(dts_pkg::REG_DELIM_LO,     map[0   +: 64]);
    write_reg(dts_pkg::REG_DELIM_MID_LO, map[64  +: 64]);
    write_reg(dts_pkg::REG_DELIM_MID_HI, map[128 +: 64]);
    write_reg(dts_pkg::REG_DELIM_HI,     map[192 +: 64]);
    write_reg(dts_pkg::REG_ALLOW_EMPTY,  {63'd0, allow_empty});
    write_reg(dts_pkg::REG_KEEP_TRAIL,   {63'd0, keep_trailing});
    write_reg(dts_pkg::REG_TRIM_TOKENS,  {63'd0, trim});
    cfg_ch.valid <= 1'b0;
    delim_codes.delete();
    for (int c = 0; c < 256; c++) begin
      if (map[c]) delim_codes.push_back(c[dts_pkg::CHAR_W-1:0]);
    end
  endtask

  // Short hand-picked strings: leading and trailing blanks, adjacent
  // delimiters, a delimiter closing two tokens at once, a string of one
  // delimiter, a blank-only string, the lowest and highest byte codes, a
  // delimiter in every word of the map, and final segments that give no
  // token at all.
  task automatic test_basic_splits();
    logic [255:0] map;
    map = '0;
    map[8'h00]      = 1'b1;
    map[CHAR_COMMA] = 1'b1;
    map[CHAR_PIPE]  = 1'b1;
    map[8'h80]      = 1'b1;
    map[8'hFF]      = 1'b1;

    configure(map, 1'b1, 1'b1, 1'b1);
    // The pipe closes a blank segment and then the trailing empty token.
    send_string(" ab ,,\t|");
    send_byte(8'hFF, 1'b1);
    send_string("\t \t");

    configure(map, 1'b0, 1'b1, 1'b0);
    // Leading empty segment is dropped; the final comma gives no trailing
    // token because empty tokens are off.
    send_byte(8'h00, 1'b0);
    send_byte("x", 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(CHAR_COMMA, 1'b1);
    send_string("q ");

    // A blank-only string trims to nothing, so no token carries the end.
    configure(map, 1'b0, 1'b0, 1'b1);
    send_string(" \t");
  endtask

  // Picks one byte for a random string: delimiters and blanks are favored
  // so that segments are short and trimming has work to do.
  function automatic logic [dts_pkg::CHAR_W-1:0] pick_char();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 35 && delim_codes.size() > 0)
      return delim_codes[$urandom_range(0, delim_codes.size() - 1)];
    if (roll < 55) return ($urandom_range(0, 1) != 0) ? dts_pkg::CHAR_SPACE : dts_pkg::CHAR_TAB;
    return 8'($urandom_range(0, 255));
  endfunction

  // Random strings under eight settings, one per combination of the three
  // mode bits. The maps include the empty map and the full map. Most
  // strings are short mixes of delimiters, blanks and content; a few are
  // plain random bytes. The last two phases run with no idling at all.
  task automatic test_mode_combinations();
    logic [255:0] map;
    int sent;
    int len;
    logic noise;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        1: map = '0;
        2: map = '1;
        5: map = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom};
        default: begin
          map = '0;
          map[CHAR_COMMA] = 1'b1;
          repeat ($urandom_range(1, 6)) map[$urandom_range(0, 255)] = 1'b1;
        end
      endcase
      configure(map, phase[0], phase[1], phase[2]);
      receiver_stalls_on = (phase < 6);
      sent = 0;
      while (sent < 150) begin
        // Stretches without sender gaps happen inside the idling phases too.
        sender_gaps_on = (phase < 6) && ($urandom_range(0, 4) != 0);
        len   = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        noise = ($urandom_range(0, 9) == 0);
        for (int i = 0; i < len; i++) begin
          send_byte(noise ? 8'($urandom_range(0, 255)) : pick_char(), i == len - 1);
        end
        sent += len;
        // Once, halfway through phase 3, the sender holds off until everything is out.
        if (phase == 3 && sent >= 75 && sent - len < 75) wait_idle();
      end
    end
    sender_gaps_on     = 1'b0;
    receiver_stalls_on = 1'b0;
  endtask

  // Test sequence. The predictor starts from the reset state of the block.
  initial begin
    delim_map         = '0;
    allow_empty_cfg   = 1'b0;
    keep_trailing_cfg = 1'b0;
    trim_cfg          = 1'b0;
    str_pos           = 0;
    seg_begin         = 0;
    first_nb_pos      = 0;
    last_nb_pos       = 0;
    seen_nb           = 1'b0;
    str_overflowed    = 1'b0;
    @(posedge rst_n);
    @(negedge clk);

    test_basic_splits();
    test_mode_combinations();

    // Drain the last tokens and give the block time to show anything extra.
    wait_idle();
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/dts_pkg.sv
rtl/dts_in_if.sv
rtl/dts_out_if.sv
rtl/dts_cfg_if.sv
rtl/dts_front.sv
rtl/dts_fifo.sv
rtl/dts_back.sv
rtl/delimited_token_splitter_top.sv
tb/delimited_token_splitter_top_test.sv
